[rtl/ctc_greedy_decoder_core_macros.svh]
// Assertion macros for the greedy CTC decoder.
// Assumes clk and arst_n are visible at the point of use.
`ifndef CTC_GREEDY_DECODER_CORE_MACROS_SVH
`define CTC_GREEDY_DECODER_CORE_MACROS_SVH

// cond must hold at every clock edge out of reset
`define CTC_GD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons must hold whenever ante holds
`define CTC_GD_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/ctc_gd_pkg.sv]
// Shared constants and types for the greedy CTC decoder.
// No dependencies.
`timescale 1ns / 1ps
package ctc_gd_pkg;
	localparam int MAX_CLASSES  = 8192;
	localparam int MAX_SEQUENCE = 1024;

	localparam int NCLS_W  = 14;
	localparam int CLASS_W = 13;
	localparam int SCORE_W = 16;
	localparam int SUM_W   = 26;
	localparam int COUNT_W = 11;

	localparam int CLASSES_LIMIT = (MAX_CLASSES < 8192) ? ((MAX_CLASSES < 2) ? 2 : MAX_CLASSES)
		: 8192;
	localparam int COUNT_LIMIT   = (MAX_SEQUENCE < 2047) ? MAX_SEQUENCE : 2047;

	localparam logic [NCLS_W-1:0] NCLS_RESET = NCLS_W'(96);
	localparam logic [NCLS_W-1:0] NCLS_MIN   = NCLS_W'(2);
	localparam logic [NCLS_W-1:0] NCLS_MAX   = NCLS_W'(CLASSES_LIMIT);
	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(COUNT_LIMIT);

	localparam int TSQ_DEPTH = 4;
	localparam int OQ_DEPTH  = 2;

	typedef struct packed {
		logic [CLASS_W-1:0] best_class;
		logic [SCORE_W-1:0] best_score;
		logic               eos;
	} ts_rec_t;

	typedef struct packed {
		logic               full;
		logic               empty;
	} tsq_stat_t;

	typedef struct packed {
		logic               char_valid;
		logic [CLASS_W-1:0] class_index;
		logic               sequence_done;
		logic [SUM_W-1:0]   score_sum;
		logic [COUNT_W-1:0] char_count;
	} result_t;
endpackage

[rtl/ctc_gd_front.sv]
// Front end: class-count register, running argmax per timestep.
// Pushes one timestep record per timestep end. Depends on ctc_gd_pkg.
`timescale 1ns / 1ps
module ctc_gd_front import ctc_gd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [NCLS_W-1:0]  cfg_data,
	input  logic               accept,
	input  logic [SCORE_W-1:0] score,
	input  logic               end_of_sequence,
	output logic               rec_push,
	output ts_rec_t            rec
);
	logic [NCLS_W-1:0]  num_classes_q;
	logic [CLASS_W-1:0] pos_q;
	logic [SCORE_W-1:0] best_score_q;
	logic [CLASS_W-1:0] best_class_q;
	logic [NCLS_W-1:0]  n_eff;
	logic               last;
	logic [SCORE_W-1:0] cur_score;
	logic [CLASS_W-1:0] cur_class;

	always_comb begin
		if (num_classes_q < NCLS_MIN) begin
			n_eff = NCLS_MIN;
		end else if (num_classes_q > NCLS_MAX) begin
			n_eff = NCLS_MAX;
		end else begin
			n_eff = num_classes_q;
		end
	end

	always_comb begin
		if (pos_q == '0) begin
			cur_score = score;
			cur_class = '0;
		end else if (score > best_score_q) begin
			cur_score = score;
			cur_class = pos_q;
		end else begin
			cur_score = best_score_q;
			cur_class = best_class_q;
		end
	end

	assign last = ({1'b0, pos_q} + NCLS_W'(1)) >= n_eff;

	assign rec_push       = accept && last;
	assign rec.best_class = cur_class;
	assign rec.best_score = cur_score;
	assign rec.eos        = end_of_sequence;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q <= NCLS_RESET;
			pos_q         <= '0;
			best_score_q  <= '0;
			best_class_q  <= '0;
		end else begin
			if (cfg_we) begin
				num_classes_q <= cfg_data;
			end
			if (accept) begin
				best_score_q <= cur_score;
				best_class_q <= cur_class;
				pos_q        <= last ? '0 : pos_q + CLASS_W'(1);
			end
		end
	end
endmodule

[rtl/ctc_gd_tsq.sv]
// Timestep record queue between front and back end.
// Depends on ctc_gd_pkg.
`timescale 1ns / 1ps
module ctc_gd_tsq import ctc_gd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  ts_rec_t   wr_rec,
	input  logic      rd,
	output ts_rec_t   rd_rec,
	output tsq_stat_t stat
);
	localparam int PTR_W = (TSQ_DEPTH > 1) ? $clog2(TSQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(TSQ_DEPTH + 1);

	ts_rec_t           mem_q [TSQ_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr;
	logic              do_rd;

	assign stat.full  = count_q == CNT_W'(TSQ_DEPTH);
	assign stat.empty = count_q == '0;
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign rd_rec     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(TSQ_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(TSQ_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end
endmodule

[rtl/ctc_gd_back.sv]
// Back end: repeat collapse, saturating sum and count, result queue.
// Depends on ctc_gd_pkg.
`timescale 1ns / 1ps
module ctc_gd_back import ctc_gd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tsq_stat_t tsq_stat,
	input  ts_rec_t   rec,
	output logic      rec_pop,
	input  logic      pop,
	output logic      empty,
	output result_t   res
);
	localparam int PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(OQ_DEPTH + 1);

	logic [CLASS_W-1:0] prev_class_q;
	logic               prev_valid_q;
	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;

	result_t            mem_q [OQ_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   oq_count_q;

	logic               do_pop;
	logic               room;
	logic               nonblank;
	logic               emit;
	logic [SUM_W:0]     sum_ext;
	logic [SUM_W-1:0]   sum_nx;
	logic [COUNT_W-1:0] count_nx;
	logic               res_wr;
	result_t            res_nx;

	assign empty   = oq_count_q == '0;
	assign do_pop  = pop && !empty;
	assign room    = (oq_count_q != CNT_W'(OQ_DEPTH)) || do_pop;
	assign rec_pop = !tsq_stat.empty && room;

	assign nonblank = rec.best_class != '0;
	assign emit     = nonblank && (!prev_valid_q || rec.best_class != prev_class_q);
	assign sum_ext  = {1'b0, sum_q} + (SUM_W + 1)'(rec.best_score);

	always_comb begin
		sum_nx = sum_q;
		if (nonblank) begin
			sum_nx = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
		end
		count_nx = count_q;
		if (emit && count_q < COUNT_MAX) begin
			count_nx = count_q + COUNT_W'(1);
		end
		res_nx.char_valid    = emit;
		res_nx.class_index   = emit ? rec.best_class : '0;
		res_nx.sequence_done = rec.eos;
		res_nx.score_sum     = rec.eos ? sum_nx : '0;
		res_nx.char_count    = rec.eos ? count_nx : '0;
	end

	assign res_wr = rec_pop && (emit || rec.eos);
	assign res    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (res_wr) begin
			mem_q[wr_ptr_q] <= res_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_class_q <= '0;
			prev_valid_q <= 1'b0;
			sum_q        <= '0;
			count_q      <= '0;
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			oq_count_q   <= '0;
		end else begin
			if (rec_pop) begin
				if (rec.eos) begin
					prev_class_q <= '0;
					prev_valid_q <= 1'b0;
					sum_q        <= '0;
					count_q      <= '0;
				end else begin
					sum_q   <= sum_nx;
					count_q <= count_nx;
					if (!nonblank) begin
						prev_valid_q <= 1'b0;
					end else if (emit) begin
						prev_class_q <= rec.best_class;
						prev_valid_q <= 1'b1;
					end
				end
			end
			if (res_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (res_wr && !do_pop) begin
				oq_count_q <= oq_count_q + CNT_W'(1);
			end else if (do_pop && !res_wr) begin
				oq_count_q <= oq_count_q - CNT_W'(1);
			end
		end
	end
endmodule

[rtl/ctc_greedy_decoder_core.sv]
// Greedy CTC decoder top level: front argmax, timestep queue, back end.
// Takes one score per cycle while full is low; each timestep record is registered
// in the timestep queue, then the back end writes its result to the output queue when that queue has room.
// full rises only when the four-entry timestep queue backs up behind pop.
// Reset clears position, repeat memory, totals and queues; class count is 96.
`timescale 1ns / 1ps
`include "ctc_greedy_decoder_core_macros.svh"
module ctc_greedy_decoder_core import ctc_gd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [NCLS_W-1:0]  cfg_data,
	input  logic               push,
	output logic               full,
	input  logic [SCORE_W-1:0] score,
	input  logic               end_of_sequence,
	output logic               empty,
	input  logic               pop,
	output logic               char_valid,
	output logic [CLASS_W-1:0] class_index,
	output logic               sequence_done,
	output logic [SUM_W-1:0]   score_sum,
	output logic [COUNT_W-1:0] char_count
);
	logic      accept;
	logic      rec_push;
	ts_rec_t   rec_in;
	ts_rec_t   rec_head;
	logic      rec_pop;
	tsq_stat_t tsq_stat;
	result_t   res;

	assign cfg_ready = 1'b1;
	assign full      = tsq_stat.full;
	assign accept    = push && !full;

	ctc_gd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.accept          (accept),
		.score           (score),
		.end_of_sequence (end_of_sequence),
		.rec_push        (rec_push),
		.rec             (rec_in)
	);

	ctc_gd_tsq u_tsq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rec_push),
		.wr_rec (rec_in),
		.rd     (rec_pop),
		.rd_rec (rec_head),
		.stat   (tsq_stat)
	);

	ctc_gd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tsq_stat (tsq_stat),
		.rec      (rec_head),
		.rec_pop  (rec_pop),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	assign char_valid    = res.char_valid;
	assign class_index   = res.class_index;
	assign sequence_done = res.sequence_done;
	assign score_sum     = res.score_sum;
	assign char_count    = res.char_count;

	`CTC_GD_ASSERT_IMPLY(a_res_nonempty, !empty, char_valid || sequence_done, "empty result queued")
	`CTC_GD_ASSERT_IMPLY(a_char_nonblank, !empty && char_valid, class_index != '0, "blank emitted")
	`CTC_GD_ASSERT_IMPLY(a_totals_zero, !empty && !sequence_done, score_sum == '0 && char_count == '0, "totals without sequence end")
	`CTC_GD_ASSERT_IMPLY(a_count_limit, !empty, char_count <= COUNT_MAX, "char count over limit")
endmodule
